>>> sv/ecrm_pkg.sv
// Shared types, codes and constants of the extent chain read mapper.
package ecrm_pkg;

    localparam int MAX_SLOTS_DEF = 16;
    localparam int RESULT_CAP    = 16;
    localparam int RUN_CW        = $clog2(RESULT_CAP + 1);
    localparam int Q_DEPTH       = 2;
    localparam int QAW           = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW           = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_MAP    = 2'd2;
    localparam logic [1:0] OP_DIRECT = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_NODATA = 2'd2;

    typedef enum logic [2:0] {
        K_CLEAR  = 3'd0,
        K_APPEND = 3'd1,
        K_MAP    = 3'd2,
        K_DIRECT = 3'd3,
        K_NODATA = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] lba;
        logic [31:0] size;
        logic [31:0] offset;
        logic [31:0] length;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> sv/ecrm_front.sv
// Front stage: registers an input word and classifies it into a command.
module ecrm_front import ecrm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_extent_lba,
    input  logic [31:0] i_extent_size,
    input  logic [31:0] i_offset,
    input  logic [31:0] i_length,
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic  r_valid;
    t_cmd  r_cmd;
    t_kind kind;
    logic  accept;

    assign o_stall = r_valid && i_q_stat.full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_q_stat.full;
    assign o_cmd   = r_cmd;

    // a read that asks for no bytes needs no walk
    always_comb begin
        case (i_opcode)
            OP_CLEAR:  kind = K_CLEAR;
            OP_APPEND: kind = K_APPEND;
            OP_MAP:    kind = (i_length == 32'd0) ? K_NODATA : K_MAP;
            OP_DIRECT: kind = (i_length == 32'd0) ? K_NODATA : K_DIRECT;
            default:   kind = K_NODATA;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.kind   <= kind;
            r_cmd.lba    <= i_extent_lba;
            r_cmd.size   <= i_extent_size;
            r_cmd.offset <= i_offset;
            r_cmd.length <= i_length;
        end
    end

endmodule

>>> sv/ecrm_fifo.sv
// Short command queue between the front stage and the walk engine.
module ecrm_fifo import ecrm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_cmd,
    output t_q_stat o_stat
);

    t_cmd             r_slot [Q_DEPTH];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   r_rd;
    logic [QCW-1:0]   r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_stat.full  = (r_cnt == QCW'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_cmd        = r_slot[r_rd];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QAW'(Q_DEPTH - 1)) ? '0 : r_wr + QAW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == QAW'(Q_DEPTH - 1)) ? '0 : r_rd + QAW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QCW'(1);
                2'b01:   r_cnt <= r_cnt - QCW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

endmodule

>>> sv/ecrm_back.sv
// Walk engine: holds the extent chain and turns commands into result words.
module ecrm_back import ecrm_pkg::*; #(
    parameter int MAX_EXTENT_SLOTS = MAX_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_q_cmd,
    input  t_q_stat     i_q_stat,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_run_lba,
    output logic [31:0] o_run_offset,
    output logic [31:0] o_run_length,
    output logic        o_last,
    output logic [1:0]  o_status
);

    localparam int AW = (MAX_EXTENT_SLOTS > 1) ? $clog2(MAX_EXTENT_SLOTS) : 1;
    localparam int CW = $clog2(MAX_EXTENT_SLOTS + 1);
    localparam logic [CW-1:0] SLOTS = CW'(MAX_EXTENT_SLOTS);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CALC   = 5'b00010,
        S_EVAL   = 5'b00100,
        S_ACT    = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state      r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic [31:0] r_logical, n_logical;
    logic [31:0] r_offset, n_offset;
    logic [31:0] r_remain, n_remain;
    logic [31:0] r_end, n_end;
    logic [31:0] r_within, n_within;
    logic        r_hit, n_hit;
    logic [31:0] r_n, n_n;
    logic [RUN_CW-1:0] r_runs, n_runs;
    logic        r_pend_valid, n_pend_valid;
    logic [31:0] r_pend_lba, n_pend_lba;
    logic [31:0] r_pend_off, n_pend_off;
    logic [31:0] r_pend_len, n_pend_len;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_lba, n_out_lba;
    logic [31:0] r_out_off, n_out_off;
    logic [31:0] r_out_len, n_out_len;
    logic        r_out_last, n_out_last;
    logic [1:0]  r_out_status, n_out_status;

    logic [31:0] r_mem_lba  [MAX_EXTENT_SLOTS];
    logic [31:0] r_mem_size [MAX_EXTENT_SLOTS];
    logic [31:0] r_rd_lba;
    logic [31:0] r_rd_size;
    logic [AW-1:0] rd_addr;
    logic        mem_we;

    logic          out_free;
    logic [CW-1:0] idx_step;
    logic [31:0]   raw_n;
    logic [31:0]   rem_next;

    assign out_free = !r_out_valid || !i_stall;
    assign idx_step = r_idx + CW'(1);
    assign raw_n    = r_rd_size - r_within;

    assign o_valid      = r_out_valid;
    assign o_run_lba    = r_out_lba;
    assign o_run_offset = r_out_off;
    assign o_run_length = r_out_len;
    assign o_last       = r_out_last;
    assign o_status     = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_logical    = r_logical;
        n_offset     = r_offset;
        n_remain     = r_remain;
        n_end        = r_end;
        n_within     = r_within;
        n_hit        = r_hit;
        n_n          = r_n;
        n_runs       = r_runs;
        n_pend_valid = r_pend_valid;
        n_pend_lba   = r_pend_lba;
        n_pend_off   = r_pend_off;
        n_pend_len   = r_pend_len;
        n_out_valid  = r_out_valid && i_stall;
        n_out_lba    = r_out_lba;
        n_out_off    = r_out_off;
        n_out_len    = r_out_len;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        o_pop        = 1'b0;
        mem_we       = 1'b0;
        rem_next     = r_remain;
        rd_addr      = (r_idx < SLOTS) ? r_idx[AW-1:0] : '0;

        case (r_state)
            S_IDLE: begin
                rd_addr = '0;
                if (!i_q_stat.empty) begin
                    if (i_q_cmd.kind == K_MAP) begin
                        o_pop     = 1'b1;
                        n_idx     = '0;
                        n_logical = 32'd0;
                        n_offset  = i_q_cmd.offset;
                        n_remain  = i_q_cmd.length;
                        n_runs    = '0;
                        n_state   = (r_count == '0) ? S_FINISH : S_CALC;
                    end else if (out_free) begin
                        o_pop        = 1'b1;
                        n_out_valid  = 1'b1;
                        n_out_lba    = 32'd0;
                        n_out_off    = 32'd0;
                        n_out_len    = 32'd0;
                        n_out_last   = 1'b1;
                        n_out_status = ST_OK;
                        case (i_q_cmd.kind)
                            K_CLEAR: begin
                                n_count = '0;
                            end
                            K_APPEND: begin
                                if (r_count < SLOTS) begin
                                    mem_we  = 1'b1;
                                    n_count = r_count + CW'(1);
                                end else begin
                                    n_out_status = ST_FULL;
                                end
                            end
                            K_DIRECT: begin
                                n_out_lba = i_q_cmd.lba;
                                n_out_off = i_q_cmd.offset;
                                n_out_len = i_q_cmd.length;
                            end
                            default: begin
                                n_out_status = ST_NODATA;
                            end
                        endcase
                    end
                end
            end
            S_CALC: begin
                n_end    = r_logical + r_rd_size;
                n_within = (r_offset > r_logical) ? r_offset - r_logical : 32'd0;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                n_hit   = r_offset < r_end;
                n_n     = (raw_n > r_remain) ? r_remain : raw_n;
                n_state = S_ACT;
            end
            S_ACT: begin
                if (r_hit && (r_n == 32'd0 || r_runs >= RUN_CW'(RESULT_CAP))) begin
                    n_state = S_FINISH;
                end else if (r_hit && r_pend_valid && !out_free) begin
                    // hold the current extent on the read port while waiting
                    n_state = S_ACT;
                end else begin
                    // prefetch the next extent while deciding on this one
                    rd_addr = (idx_step < SLOTS) ? idx_step[AW-1:0] : '0;
                    if (r_hit) begin
                        // the held run is not the last one: release it
                        if (r_pend_valid) begin
                            n_out_valid  = 1'b1;
                            n_out_lba    = r_pend_lba;
                            n_out_off    = r_pend_off;
                            n_out_len    = r_pend_len;
                            n_out_last   = 1'b0;
                            n_out_status = ST_OK;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_lba   = r_rd_lba;
                        n_pend_off   = r_within;
                        n_pend_len   = r_n;
                        n_runs       = r_runs + RUN_CW'(1);
                        rem_next     = r_remain - r_n;
                        n_offset     = r_offset + r_n;
                    end
                    n_remain  = rem_next;
                    n_logical = r_end;
                    n_idx     = idx_step;
                    n_state   = (idx_step < r_count && rem_next != 32'd0) ? S_CALC : S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    if (r_pend_valid) begin
                        n_out_lba    = r_pend_lba;
                        n_out_off    = r_pend_off;
                        n_out_len    = r_pend_len;
                        n_out_status = ST_OK;
                    end else begin
                        n_out_lba    = 32'd0;
                        n_out_off    = 32'd0;
                        n_out_len    = 32'd0;
                        n_out_status = ST_NODATA;
                    end
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_runs       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_runs       <= n_runs;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_logical    <= n_logical;
        r_offset     <= n_offset;
        r_remain     <= n_remain;
        r_end        <= n_end;
        r_within     <= n_within;
        r_hit        <= n_hit;
        r_n          <= n_n;
        r_pend_lba   <= n_pend_lba;
        r_pend_off   <= n_pend_off;
        r_pend_len   <= n_pend_len;
        r_out_lba    <= n_out_lba;
        r_out_off    <= n_out_off;
        r_out_len    <= n_out_len;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_lba[r_count[AW-1:0]]  <= i_q_cmd.lba;
            r_mem_size[r_count[AW-1:0]] <= i_q_cmd.size;
        end
        r_rd_lba  <= r_mem_lba[rd_addr];
        r_rd_size <= r_mem_size[rd_addr];
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SLOTS)
        else $error("extent count beyond slot count");

    a_runs_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_runs <= RUN_CW'(RESULT_CAP))
        else $error("run count beyond cap");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("held run left over after a walk");

    a_nodata_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_NODATA) |-> (o_last && o_run_length == 32'd0))
        else $error("empty result not final or not zero length");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE && !i_q_stat.empty))
        else $error("queue popped outside idle or while empty");
`endif

endmodule

>>> sv/extent_chain_read_mapper.sv
// Top level of the extent chain read mapper: front stage, command queue, walk engine.
//
//  channel   direction  handshake          payload
//  input     in         i_valid/o_stall    i_opcode i_extent_lba i_extent_size i_offset i_length
//  result    out        o_valid/i_stall    o_run_lba o_run_offset o_run_length o_last o_status
//
// Clear, append and direct read go straight through the walk engine, one word out.
// A map read walks the chain extent by extent; the walk engine spends three steps
// per extent (sum, compare and clamp, update) on one chain memory port.
// A word waits in the front register and a two-deep queue before the walk engine.
// Reset is synchronous and active low; it empties the chain and the queue.
// A stall on the result side holds the walk; the input side keeps filling the queue.
module extent_chain_read_mapper import ecrm_pkg::*; #(
    parameter int MAX_EXTENT_SLOTS = MAX_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_extent_lba,
    input  logic [31:0] i_extent_size,
    input  logic [31:0] i_offset,
    input  logic [31:0] i_length,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_run_lba,
    output logic [31:0] o_run_offset,
    output logic [31:0] o_run_length,
    output logic        o_last,
    output logic [1:0]  o_status
);

    t_q_stat q_stat;
    t_cmd    push_cmd;
    t_cmd    q_cmd;
    logic    push;
    logic    pop;

    ecrm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_extent_lba  (i_extent_lba),
        .i_extent_size (i_extent_size),
        .i_offset      (i_offset),
        .i_length      (i_length),
        .i_q_stat      (q_stat),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    ecrm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    ecrm_back #(
        .MAX_EXTENT_SLOTS (MAX_EXTENT_SLOTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_cmd      (q_cmd),
        .i_q_stat     (q_stat),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_run_lba    (o_run_lba),
        .o_run_offset (o_run_offset),
        .o_run_length (o_run_length),
        .o_last       (o_last),
        .o_status     (o_status)
    );

endmodule

>>> dv/extent_chain_read_mapper_tb.sv
// Self-checking testbench for the extent chain read mapper: directed and random words.
module extent_chain_read_mapper_tb;
    import ecrm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [31:0] lba;
        logic [31:0] offset;
        logic [31:0] length;
        logic        last;
        logic [1:0]  status;
    } t_run_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = OP_CLEAR;
    logic [31:0] i_extent_lba = '0;
    logic [31:0] i_extent_size = '0;
    logic [31:0] i_offset = '0;
    logic [31:0] i_length = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_run_lba;
    logic [31:0] o_run_offset;
    logic [31:0] o_run_length;
    logic        o_last;
    logic [1:0]  o_status;

    // Shadow of the chain, updated as each word is accepted.
    logic [31:0] chain_lba [MAX_SLOTS_DEF];
    logic [31:0] chain_size [MAX_SLOTS_DEF];
    int          chain_len = 0;

    t_run_word   pending_runs[$];
    int          words_sent = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          steady = 1'b0;

    extent_chain_read_mapper u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_extent_lba  (i_extent_lba),
        .i_extent_size (i_extent_size),
        .i_offset      (i_offset),
        .i_length      (i_length),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_run_lba     (o_run_lba),
        .o_run_offset  (o_run_offset),
        .o_run_length  (o_run_length),
        .o_last        (o_last),
        .o_status      (o_status)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_run_word make_run(input logic [31:0] lba, input logic [31:0] offset,
                                           input logic [31:0] length, input logic last,
                                           input logic [1:0] status);
        t_run_word r;
        r.lba = lba;
        r.offset = offset;
        r.length = length;
        r.last = last;
        r.status = status;
        return r;
    endfunction

    task automatic predict_runs(input logic [1:0] op, input logic [31:0] lba,
                                input logic [31:0] size, input logic [31:0] offset,
                                input logic [31:0] length);
        logic [31:0] base;
        logic [31:0] stop;
        logic [31:0] skip;
        logic [31:0] n;
        logic [31:0] remain;
        logic [31:0] cur;
        int          runs;
        int          e;
        case (op)
            OP_CLEAR: begin
                chain_len = 0;
                pending_runs.push_back(make_run('0, '0, '0, 1'b1, ST_OK));
            end
            OP_APPEND: begin
                if (chain_len < MAX_SLOTS_DEF) begin
                    chain_lba[chain_len] = lba;
                    chain_size[chain_len] = size;
                    chain_len++;
                    pending_runs.push_back(make_run('0, '0, '0, 1'b1, ST_OK));
                end else begin
                    pending_runs.push_back(make_run('0, '0, '0, 1'b1, ST_FULL));
                end
            end
            OP_DIRECT: begin
                if (length == 0)
                    pending_runs.push_back(make_run('0, '0, '0, 1'b1, ST_NODATA));
                else
                    pending_runs.push_back(make_run(lba, offset, length, 1'b1, ST_OK));
            end
            default: begin
                base = '0;
                remain = length;
                cur = offset;
                runs = 0;
                // Walk extents in order; logical sums wrap at 32 bits.
                for (e = 0; e < chain_len && remain != 0; e++) begin
                    stop = base + chain_size[e];
                    if (cur < stop) begin
                        skip = (cur > base) ? cur - base : '0;
                        n = chain_size[e] - skip;
                        if (n > remain)
                            n = remain;
                        if (n == 0 || runs >= RESULT_CAP)
                            break;
                        pending_runs.push_back(make_run(chain_lba[e], skip, n, 1'b0, ST_OK));
                        runs++;
                        remain = remain - n;
                        cur = cur + n;
                    end
                    base = stop;
                end
                if (runs == 0)
                    pending_runs.push_back(make_run('0, '0, '0, 1'b1, ST_NODATA));
                else
                    pending_runs[pending_runs.size() - 1].last = 1'b1;
            end
        endcase
    endtask

    // Called at a rising edge; returns at the rising edge that accepts the word.
    task automatic send_word(input logic [1:0] op, input logic [31:0] lba,
                             input logic [31:0] size, input logic [31:0] offset,
                             input logic [31:0] length);
        if (!steady && $urandom_range(0, 99) < 22) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_extent_lba <= lba;
        i_extent_size <= size;
        i_offset <= offset;
        i_length <= length;
        // Stall is stable by the falling edge, so decide acceptance there.
        forever begin
            @(negedge i_clk);
            if (!o_stall)
                break;
        end
        predict_runs(op, lba, size, offset, length);
        words_sent++;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        i_stall <= !steady && ($urandom_range(0, 99) < 22);
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge i_clk) begin
        t_run_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_runs.size() == 0) begin
                $display("%0t: expected no word, got lba %h offset %h length %h last %b status %h",
                         $time, o_run_lba, o_run_offset, o_run_length, o_last, o_status);
                mismatches++;
            end else begin
                want = pending_runs.pop_front();
                compare_field("run_lba", want.lba, o_run_lba);
                compare_field("run_offset", want.offset, o_run_offset);
                compare_field("run_length", want.length, o_run_length);
                compare_field("last", 32'(want.last), 32'(o_last));
                compare_field("status", 32'(want.status), 32'(o_status));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("extent_chain_read_mapper_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [31:0] pick_size(input bit dense);
        if (dense)
            return $urandom_range(1, 64);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return $urandom;
            2: return ($urandom_range(0, 1) != 0) ? 32'hffff_ffff : 32'h8000_0000;
            3: return 32'h7fff_ffff;
            default: return $urandom_range(1, 256);
        endcase
    endfunction

    function automatic logic [31:0] pick_length();
        case ($urandom_range(0, 9))
            0: return '0;
            1, 2: return 32'hffff_ffff;
            3: return $urandom;
            default: return $urandom_range(1, 512);
        endcase
    endfunction

    task automatic test_empty_chain();
        send_word(OP_MAP, '0, '0, '0, 32'hffff_ffff);
        send_word(OP_DIRECT, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, '0);
    endtask

    task automatic test_direct_read();
        send_word(OP_DIRECT, 32'hffff_ffff, '0, 32'hffff_ffff, 32'hffff_ffff);
    endtask

    task automatic test_full_chain_walk();
        int k;
        logic [31:0] size;
        send_word(OP_CLEAR, '0, '0, '0, '0);
        // Slot 1 is empty and the last slot wraps the logical end.
        for (k = 0; k < MAX_SLOTS_DEF; k++) begin
            size = (k == 1) ? '0 : (k == MAX_SLOTS_DEF - 1) ? 32'hffff_ffff : 32'h10;
            send_word(OP_APPEND, k[0] ? ~32'(k) : 32'(k), size, '0, '0);
        end
        send_word(OP_APPEND, 32'h1234_5678, 32'h40, '0, '0);
        send_word(OP_MAP, '0, '0, '0, 32'hffff_ffff);
        send_word(OP_MAP, '0, '0, 32'h25, 32'h30);
        send_word(OP_MAP, '0, '0, 32'h8, '0);
        send_word(OP_MAP, '0, '0, 32'hffff_fffe, 32'h5);
    endtask

    task automatic test_random_sessions(input int words);
        int          start;
        int          appends;
        int          maps;
        int          k;
        bit          dense;
        longint      total;
        logic [31:0] offset;
        start = words_sent;
        while (words_sent - start < words) begin
            steady = (words_sent - start >= 150) && (words_sent - start < 250);
            dense = ($urandom_range(0, 3) == 0);
            send_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
            appends = dense ? $urandom_range(MAX_SLOTS_DEF - 1, MAX_SLOTS_DEF + 1)
                            : $urandom_range(1, MAX_SLOTS_DEF + 1);
            for (k = 0; k < appends; k++)
                send_word(OP_APPEND, $urandom, pick_size(dense), $urandom, $urandom);
            total = 0;
            for (k = 0; k < chain_len; k++)
                total += chain_size[k];
            maps = $urandom_range(1, 6);
            for (k = 0; k < maps; k++) begin
                if (total <= 64'hffff_ffff && $urandom_range(0, 9) < 7)
                    offset = $urandom_range(0, 32'(total));
                else
                    offset = $urandom;
                send_word(OP_MAP, $urandom, $urandom, offset, pick_length());
            end
        end
        steady = 1'b0;
    endtask

    task automatic test_random_noise(input int words);
        int start;
        start = words_sent;
        while (words_sent - start < words)
            send_word(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, pick_length());
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_chain();
        test_direct_read();
        test_full_chain_walk();
        test_random_sessions(340);
        test_random_noise(80);
        i_valid <= 1'b0;
        while (pending_runs.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("extent_chain_read_mapper_tb OK");
        else
            $display("extent_chain_read_mapper_tb NOT OK");
        $finish;
    end

endmodule
